// ===== rtl/epr_pkg.sv =====
`timescale 1ns / 1ps
package epr_pkg;

	// Field widths
	localparam int COORD_W = 24;
	localparam int ANGLE_W = 16;
	localparam int GUARD_W = 8;
	// Internal coordinate width: guard bits plus headroom for rotation growth
	localparam int INT_W   = 36;
	// Residual angle accumulator, units of 2^-32 turn
	localparam int ZACC_W  = 33;
	localparam int ATAN_LEN = 24;

	// Gain compensation, Q20
	localparam logic signed [20:0] GAIN_Q20 = 21'sd636751;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TBL [0:ATAN_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PITCH = 2'd0,
		REG_YAW   = 2'd1,
		REG_ROLL  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
	} vtx_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      clipped;
	} res_word_t;

endpackage

// ===== rtl/epr_plane.sv =====
`timescale 1ns / 1ps
// One plane rotation: quadrant fold and gain in one stage, then one CORDIC
// micro-rotation per stage. The third coordinate rides along.
module epr_plane #(
	parameter int STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  src_valid,
	input  logic signed [epr_pkg::INT_W-1:0]      src_a,
	input  logic signed [epr_pkg::INT_W-1:0]      src_b,
	input  logic signed [epr_pkg::INT_W-1:0]      src_c,
	input  logic        [epr_pkg::ANGLE_W-1:0]    angle,
	output logic                                  dst_valid,
	output logic signed [epr_pkg::INT_W-1:0]      dst_a,
	output logic signed [epr_pkg::INT_W-1:0]      dst_b,
	output logic signed [epr_pkg::INT_W-1:0]      dst_c
);

	localparam int W  = epr_pkg::INT_W;
	localparam int ZW = epr_pkg::ZACC_W;
	localparam int AW = epr_pkg::ANGLE_W;
	localparam int PW = W + 21;
	localparam logic signed [PW-1:0] GAIN_RND = PW'(524288);

	logic              v_s [0:STEPS];
	logic signed [W-1:0]  a_s [0:STEPS];
	logic signed [W-1:0]  b_s [0:STEPS];
	logic signed [W-1:0]  c_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];

	// Angle split: quarter turns plus residual in [-1/8, 1/8) turn
	logic [AW-1:0] t_ang;
	logic [AW-1:0] t_off;
	logic [1:0]    quad;
	logic [AW-1:0] resid;
	logic signed [W-1:0]  a_rot;
	logic signed [W-1:0]  b_rot;
	logic signed [PW-1:0] a_prod;
	logic signed [PW-1:0] b_prod;
	logic signed [PW-1:0] a_scl;
	logic signed [PW-1:0] b_scl;
	logic signed [ZW-1:0] z_init;

	always_comb begin
		t_ang  = AW'(0) - angle;
		t_off  = t_ang + AW'(1 << (AW - 3));
		quad   = t_off[AW-1:AW-2];
		resid  = t_ang - {quad, {(AW-2){1'b0}}};
		z_init = {{(ZW-32+1){resid[AW-1]}}, resid[AW-2:0], {(32-AW){1'b0}}};
		case (quad)
			2'd1: begin
				a_rot = -src_b;
				b_rot = src_a;
			end
			2'd2: begin
				a_rot = -src_a;
				b_rot = -src_b;
			end
			2'd3: begin
				a_rot = src_b;
				b_rot = -src_a;
			end
			default: begin
				a_rot = src_a;
				b_rot = src_b;
			end
		endcase
		a_prod = PW'(a_rot) * PW'(epr_pkg::GAIN_Q20);
		b_prod = PW'(b_rot) * PW'(epr_pkg::GAIN_Q20);
		a_scl  = (a_prod + GAIN_RND) >>> 20;
		b_scl  = (b_prod + GAIN_RND) >>> 20;
	end

	// Gain stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s[0] <= a_scl[W-1:0];
			b_s[0] <= b_scl[W-1:0];
			c_s[0] <= src_c;
			z_s[0] <= z_init;
		end
	end

	// Micro-rotation stages
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [W-1:0]  da;
		logic signed [W-1:0]  db;
		logic signed [ZW-1:0] at;

		assign da = b_s[i] >>> i;
		assign db = a_s[i] >>> i;
		assign at = ZW'(epr_pkg::ATAN_TBL[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s[i+1] <= c_s[i];
				if (!z_s[i][ZW-1]) begin
					a_s[i+1] <= a_s[i] - da;
					b_s[i+1] <= b_s[i] + db;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					a_s[i+1] <= a_s[i] + da;
					b_s[i+1] <= b_s[i] - db;
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	assign dst_valid = v_s[STEPS];
	assign dst_a     = a_s[STEPS];
	assign dst_b     = b_s[STEPS];
	assign dst_c     = c_s[STEPS];

endmodule

// ===== rtl/euler_point_rotation.sv =====
`timescale 1ns / 1ps
// Channel  | signals                   | word
// vertex   | vtx_valid, vtx_stall, vtx | vtx_word_t (in_x, in_y, in_z)
// result   | res_valid, res_stall, res | res_word_t (out_x..out_z, clipped)
// config   | cfg_we, cfg_index, cfg_data | pitch, yaw, roll angles
//
// One vertex per cycle while no result word is held. Three plane rotations of
// one gain stage and CORDIC_STEPS micro-rotation stages each, then a combinational
// round and saturate feeding the output register.
// Reset clears valid bits and the angle registers.
// A stall on a valid result word freezes the whole pipeline; nothing is dropped.
module euler_point_rotation #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vtx_valid,
	output logic                            vtx_stall,
	input  epr_pkg::vtx_word_t              vtx,
	output logic                            res_valid,
	input  logic                            res_stall,
	output epr_pkg::res_word_t              res,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [epr_pkg::ANGLE_W-1:0]     cfg_data
);

	localparam int W  = epr_pkg::INT_W;
	localparam int CW = epr_pkg::COORD_W;
	localparam int GW = epr_pkg::GUARD_W;
	localparam int RW = W - GW;
	localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (CW - 1)) - 1);
	localparam logic signed [RW-1:0] SAT_LO = -RW'(1 << (CW - 1));

	logic [epr_pkg::ANGLE_W-1:0] pitch_q;
	logic [epr_pkg::ANGLE_W-1:0] yaw_q;
	logic [epr_pkg::ANGLE_W-1:0] roll_q;
	logic en;

	// Angle registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			yaw_q   <= '0;
			roll_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				epr_pkg::REG_PITCH: pitch_q <= cfg_data;
				epr_pkg::REG_YAW:   yaw_q   <= cfg_data;
				epr_pkg::REG_ROLL:  roll_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Whole pipeline advances unless the output word is held
	assign en        = !(res_valid && res_stall);
	assign vtx_stall = !en;

	// Widen to internal format with guard bits
	logic signed [W-1:0] wx, wy, wz;
	assign wx = {{(W-CW-GW){vtx.in_x[CW-1]}}, vtx.in_x, {GW{1'b0}}};
	assign wy = {{(W-CW-GW){vtx.in_y[CW-1]}}, vtx.in_y, {GW{1'b0}}};
	assign wz = {{(W-CW-GW){vtx.in_z[CW-1]}}, vtx.in_z, {GW{1'b0}}};

	logic v1, v2, v3;
	logic signed [W-1:0] x1, y1, z1, y2, z2, x2, z3, x3, y3;

	// Roll in x-y
	epr_plane #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .arst_n(arst_n), .en(en),
		.src_valid(vtx_valid), .src_a(wx), .src_b(wy), .src_c(wz),
		.angle(roll_q),
		.dst_valid(v1), .dst_a(x1), .dst_b(y1), .dst_c(z1)
	);

	// Pitch in y-z
	epr_plane #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en),
		.src_valid(v1), .src_a(y1), .src_b(z1), .src_c(x1),
		.angle(pitch_q),
		.dst_valid(v2), .dst_a(y2), .dst_b(z2), .dst_c(x2)
	);

	// Yaw in z-x
	epr_plane #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .arst_n(arst_n), .en(en),
		.src_valid(v2), .src_a(z2), .src_b(x2), .src_c(y2),
		.angle(yaw_q),
		.dst_valid(v3), .dst_a(z3), .dst_b(x3), .dst_c(y3)
	);

	// Round half up and saturate
	logic signed [W-1:0]  sx, sy, sz;
	logic signed [RW-1:0] rx, ry, rz;
	logic signed [CW-1:0] ox, oy, oz;
	logic cx, cy, cz;

	always_comb begin
		sx = (x3 + W'(1 << (GW - 1))) >>> GW;
		sy = (y3 + W'(1 << (GW - 1))) >>> GW;
		sz = (z3 + W'(1 << (GW - 1))) >>> GW;
		rx = sx[RW-1:0];
		ry = sy[RW-1:0];
		rz = sz[RW-1:0];
		cx = (rx > SAT_HI) || (rx < SAT_LO);
		cy = (ry > SAT_HI) || (ry < SAT_LO);
		cz = (rz > SAT_HI) || (rz < SAT_LO);
		ox = (rx > SAT_HI) ? SAT_HI[CW-1:0] : (rx < SAT_LO) ? SAT_LO[CW-1:0] : rx[CW-1:0];
		oy = (ry > SAT_HI) ? SAT_HI[CW-1:0] : (ry < SAT_LO) ? SAT_LO[CW-1:0] : ry[CW-1:0];
		oz = (rz > SAT_HI) ? SAT_HI[CW-1:0] : (rz < SAT_LO) ? SAT_LO[CW-1:0] : rz[CW-1:0];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.out_x   <= ox;
			res.out_y   <= oy;
			res.out_z   <= oz;
			res.clipped <= cx || cy || cz;
		end
	end

	// Input stalls only behind a held result word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_stall |-> (res_valid && res_stall))
		else $error("vertex stalled without a held result");

	// A clipped result sits at an end of the range
	a_clip_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.clipped) |->
			(res.out_x == SAT_HI[CW-1:0] || res.out_x == SAT_LO[CW-1:0] ||
			 res.out_y == SAT_HI[CW-1:0] || res.out_y == SAT_LO[CW-1:0] ||
			 res.out_z == SAT_HI[CW-1:0] || res.out_z == SAT_LO[CW-1:0]))
		else $error("clip flag without saturated coordinate");

	// A new result word comes only from the last plane
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(v3))
		else $error("result valid without pipeline data");

endmodule

// ===== sim/euler_point_rotation_tb.sv =====
`timescale 1ns / 1ps
module euler_point_rotation_tb;

	localparam logic [1:0] REG_UNUSED = 2'd3;   // no register behind this index
	localparam int SETTLE = 3 * 17 + 1 + 10;    // pipeline depth plus margin
	localparam int LIMIT = 300000;
	localparam int HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vtx_valid = 1'b0;
	logic vtx_stall;
	epr_pkg::vtx_word_t vtx = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	epr_pkg::res_word_t res;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = epr_pkg::REG_PITCH;
	logic [epr_pkg::ANGLE_W-1:0] cfg_data = '0;

	euler_point_rotation uut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// angles as the block holds them
	logic [epr_pkg::ANGLE_W-1:0] pitch_q = '0, yaw_q = '0, roll_q = '0;

	epr_pkg::vtx_word_t vertex_queue[$];
	epr_pkg::res_word_t rotated_queue[$];
	int errors = 0;
	int idle_pct = 20;
	bit hold_go = 1'b0, hold_done = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// turn (a,b) by minus ang, ang measured from +a toward +b
	function automatic void turn_plane(inout longint a, inout longint b,
			input logic [epr_pkg::ANGLE_W-1:0] ang);
		logic [epr_pkg::ANGLE_W-1:0] t, rr;
		logic [1:0] q;
		longint z, x, y, nx, dx, dy;
		t = '0 - ang;
		q = 2'((t + 16'h2000) >> 14);
		rr = t - (epr_pkg::ANGLE_W'(q) << 14);
		z = longint'($signed(rr)) <<< 16;
		x = a;
		y = b;
		case (q)
			2'd1: begin nx = -y; y = x; x = nx; end
			2'd2: begin x = -x; y = -y; end
			2'd3: begin nx = y; y = -x; x = nx; end
			default: ;
		endcase
		x = (x * longint'(epr_pkg::GAIN_Q20) + (64'sd1 <<< 19)) >>> 20;
		y = (y * longint'(epr_pkg::GAIN_Q20) + (64'sd1 <<< 19)) >>> 20;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(epr_pkg::ATAN_TBL[i]);
			end else begin
				x += dx; y -= dy; z += longint'(epr_pkg::ATAN_TBL[i]);
			end
		end
		a = x;
		b = y;
	endfunction

	function automatic logic [epr_pkg::COORD_W-1:0] to_coord(input longint v,
			inout logic clip);
		longint r;
		r = (v + 128) >>> epr_pkg::GUARD_W;
		if (r > 64'sd8388607) begin r = 64'sd8388607; clip = 1'b1; end
		if (r < -64'sd8388608) begin r = -64'sd8388608; clip = 1'b1; end
		return r[epr_pkg::COORD_W-1:0];
	endfunction

	function automatic epr_pkg::res_word_t rotate_vertex(input epr_pkg::vtx_word_t v);
		longint x, y, z;
		logic clip;
		epr_pkg::res_word_t r;
		x = longint'(v.in_x) <<< epr_pkg::GUARD_W;
		y = longint'(v.in_y) <<< epr_pkg::GUARD_W;
		z = longint'(v.in_z) <<< epr_pkg::GUARD_W;
		clip = 1'b0;
		turn_plane(x, y, roll_q);
		turn_plane(y, z, pitch_q);
		turn_plane(z, x, yaw_q);
		r.out_x = to_coord(x, clip);
		r.out_y = to_coord(y, clip);
		r.out_z = to_coord(z, clip);
		r.clipped = clip;
		return r;
	endfunction

	// vertex driver
	always @(posedge clk) begin
		if (vtx_valid && !vtx_stall)
			rotated_queue.push_back(rotate_vertex(vtx));
		if (!(vtx_valid && vtx_stall)) begin
			if (arst_n && vertex_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				vtx <= vertex_queue.pop_front();
				vtx_valid <= 1'b1;
			end else begin
				vtx_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		epr_pkg::res_word_t want;
		if (res_valid && !res_stall) begin
			if (rotated_queue.size() == 0) begin
				$display("unexpected result word at %0t", $realtime);
				errors++;
			end else begin
				want = rotated_queue.pop_front();
				if (res.out_x !== want.out_x) report("out_x", res.out_x, want.out_x);
				if (res.out_y !== want.out_y) report("out_y", res.out_y, want.out_y);
				if (res.out_z !== want.out_z) report("out_z", res.out_z, want.out_z);
				if (res.clipped !== want.clipped) report("clipped", res.clipped, want.clipped);
			end
		end
		res_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_angle(input logic [1:0] idx,
			input logic [epr_pkg::ANGLE_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			epr_pkg::REG_PITCH: pitch_q = val;
			epr_pkg::REG_YAW:   yaw_q = val;
			epr_pkg::REG_ROLL:  roll_q = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_angles(input logic [epr_pkg::ANGLE_W-1:0] p, y, r);
		write_angle(epr_pkg::REG_PITCH, p);
		write_angle(epr_pkg::REG_YAW, y);
		write_angle(epr_pkg::REG_ROLL, r);
	endtask

	function automatic logic [epr_pkg::COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return epr_pkg::COORD_W'($urandom);
			1: return epr_pkg::COORD_W'($signed($urandom_range(2 * 65536)) - 65536);
			default: return epr_pkg::COORD_W'($signed($urandom_range(2 * 4000000)) - 4000000);
		endcase
	endfunction

	task automatic add_vertex(input logic [epr_pkg::COORD_W-1:0] x, y, z);
		epr_pkg::vtx_word_t w;
		w.in_x = x;
		w.in_y = y;
		w.in_z = z;
		vertex_queue.push_back(w);
	endtask

	task automatic add_random(input int n);
		repeat (n) add_vertex(rand_coord(), rand_coord(), rand_coord());
	endtask

	// wait until every word is through, then let the pipeline drain
	task automatic drain();
		while (vertex_queue.size() != 0 || vtx_valid || rotated_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset angles, directed extremes and zero vector
		add_vertex('0, '0, '0);
		add_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		add_vertex(24'h800000, 24'h800000, 24'h800000);
		add_vertex(24'h000100, '0, '0);
		add_vertex('0, 24'h000100, '0);
		add_vertex('0, '0, 24'h000100);
		drain();

		// all angles at the top of the range, unused index write ignored
		set_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		write_angle(REG_UNUSED, 16'h1234);
		add_vertex('0, '0, '0);
		add_vertex(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		add_vertex(24'h800000, 24'h7FFFFF, 24'h800000);
		add_vertex(24'h400000, 24'h400000, 24'h400000);
		add_vertex(24'hFFFFFF, 24'h000001, 24'hFFFFFF);
		drain();

		// quarter turns and residual boundaries
		set_angles(16'h4000, 16'h8000, 16'hC000);
		add_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		add_vertex(24'h012345, 24'hFEDCBA, 24'h000100);
		add_vertex('0, '0, 24'h000100);
		drain();
		set_angles(16'h2000, 16'hE000, 16'h1FFF);
		add_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		add_vertex(24'h800000, 24'h000000, 24'h7FFFFF);
		add_vertex('0, '0, '0);
		add_vertex(24'h000100, '0, '0);
		drain();

		// random phases, one without idling, one with a long receiver hold-off
		idle_pct = 0;
		set_angles(16'($urandom), 16'($urandom), 16'($urandom));
		add_random(150);
		drain();
		idle_pct = 20;
		set_angles(16'($urandom), 16'($urandom), 16'($urandom));
		hold_go = 1'b1;
		add_random(200);
		drain();
		repeat (4) begin
			set_angles(16'($urandom), 16'($urandom), 16'($urandom));
			add_random(120);
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
